>>> hdl/hcf_pkg.sv
// ----------------------------------------------------------------------------
// hcf_pkg: shared definitions for the hall capture frequency estimator
// Field widths, register indexes, reset values and controller/datapath links.
// ----------------------------------------------------------------------------
package hcf_pkg;

  // Fixed field widths
  localparam int CFG_W     = 32;  // widest configuration register
  localparam int CFG_IDX_W = 2;   // register index width
  localparam int TMO_W     = 16;  // timeout_ticks and idle counter
  localparam int CAP_IN_W  = 32;  // capture_count port
  localparam int OUT_W     = 41;  // elec_freq, signed
  localparam int DIFF_W    = CFG_W + 2;  // signed difference plus wrap period
  localparam int MAG_W     = CFG_W + 1;  // divisor magnitude

  // Parameter defaults
  localparam int COUNT_WIDTH_DEF    = 32;
  localparam int FREQ_FRAC_BITS_DEF = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_CLOCK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT        = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_COUNTER_PERIOD = 32'hFFFF_FFFF;
  localparam logic [CFG_W-1:0] RST_COUNTER_CLOCK  = 32'd64_000_000;
  localparam logic [CFG_W-1:0] RST_MIN_INTERVAL   = 32'd6400;
  localparam logic [TMO_W-1:0] RST_TIMEOUT        = 16'd2000;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // take the input request
    logic step_diff;  // form the wrap-corrected difference
    logic step_mag;   // form the divisor magnitude
    logic div_start;  // launch the serial divider
    logic step_sat;   // apply sign and saturate the quotient
    logic load_out;   // move the result into the output register
  } hcf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic eq;        // capture equals the stored capture
    logic div_busy;  // divider still iterating
  } hcf_status_t;

endpackage

>>> hdl/hcf_divider.sv
// ----------------------------------------------------------------------------
// hcf_divider: restoring serial divider
// Produces one quotient bit per cycle until all NUM_W quotient bits are formed.
// ----------------------------------------------------------------------------
module hcf_divider #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numerator,
  input  logic [DEN_W-1:0] denominator,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign shifted = {rem, quo[NUM_W-1]};
  assign trial   = shifted - {1'b0, den};
  assign ge      = !trial[DEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= denominator;
      quo <= numerator;
    end else if (cnt != '0) begin
      rem <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

  assign busy     = (cnt != '0);
  assign quotient = quo;

endmodule

>>> hdl/hcf_datapath.sv
// ----------------------------------------------------------------------------
// hcf_datapath: capture difference, divisor guard, division and output
// Holds the configuration registers, the estimator state and the result.
// ----------------------------------------------------------------------------
module hcf_datapath #(
  parameter int COUNT_WIDTH    = hcf_pkg::COUNT_WIDTH_DEF,
  parameter int FREQ_FRAC_BITS = hcf_pkg::FREQ_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hcf_pkg::CFG_W-1:0]         cfg_data,
  input  logic [hcf_pkg::CAP_IN_W-1:0]      capture_count,
  input  hcf_pkg::hcf_cmd_t                 cmd,
  output hcf_pkg::hcf_status_t              status,
  output logic signed [hcf_pkg::OUT_W-1:0]  elec_freq,
  output logic                              stopped
);

  localparam int CFG_W  = hcf_pkg::CFG_W;
  localparam int TMO_W  = hcf_pkg::TMO_W;
  localparam int OUT_W  = hcf_pkg::OUT_W;
  localparam int DIFF_W = hcf_pkg::DIFF_W;
  localparam int MAG_W  = hcf_pkg::MAG_W;
  localparam int NUM_W  = CFG_W + FREQ_FRAC_BITS;
  localparam int SAT_W  = (NUM_W > OUT_W + 1) ? NUM_W : OUT_W + 1;
  localparam logic [SAT_W-1:0] POS_LIMIT = (SAT_W'(1) << (OUT_W - 1)) - SAT_W'(1);
  localparam logic [SAT_W-1:0] NEG_LIMIT = SAT_W'(1) << (OUT_W - 1);

  // Configuration
  logic [CFG_W-1:0] counter_period;
  logic [CFG_W-1:0] counter_clock_hz;
  logic [CFG_W-1:0] min_interval_counts;
  logic [TMO_W-1:0] timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_period      <= hcf_pkg::RST_COUNTER_PERIOD;
      counter_clock_hz    <= hcf_pkg::RST_COUNTER_CLOCK;
      min_interval_counts <= hcf_pkg::RST_MIN_INTERVAL;
      timeout_ticks       <= hcf_pkg::RST_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcf_pkg::REG_COUNTER_PERIOD: counter_period      <= cfg_data;
        hcf_pkg::REG_COUNTER_CLOCK:  counter_clock_hz    <= cfg_data;
        hcf_pkg::REG_MIN_INTERVAL:   min_interval_counts <= cfg_data;
        hcf_pkg::REG_TIMEOUT:        timeout_ticks       <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Estimator state
  logic [COUNT_WIDTH-1:0] cap_in;
  logic [COUNT_WIDTH-1:0] last_capture;
  logic [COUNT_WIDTH-1:0] prev_capture;
  logic [TMO_W-1:0]       idle_ticks;
  logic                   upd;        // this request runs the division
  logic                   stop_hit;   // this request forces zero

  assign cap_in    = capture_count[COUNT_WIDTH-1:0];
  assign status.eq = (cap_in == last_capture);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_capture <= '0;
      idle_ticks   <= '0;
    end else if (cmd.accept) begin
      last_capture <= cap_in;
      if (!status.eq) begin
        idle_ticks <= '0;
      end else if (idle_ticks < timeout_ticks) begin
        idle_ticks <= idle_ticks + TMO_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prev_capture <= last_capture;
      upd          <= !status.eq;
      stop_hit     <= status.eq && !(idle_ticks < timeout_ticks);
    end
  end

  // Wrap-corrected difference
  logic [DIFF_W-1:0]        wrap_u;
  logic [DIFF_W-1:0]        half_u;
  logic signed [DIFF_W-1:0] d_raw;
  logic signed [DIFF_W-1:0] diff_r;

  assign wrap_u = DIFF_W'(counter_period) + DIFF_W'(1);
  assign half_u = wrap_u >> 1;
  assign d_raw  = $signed(DIFF_W'(last_capture)) - $signed(DIFF_W'(prev_capture));

  always_ff @(posedge clk) begin
    if (cmd.step_diff) begin
      if (d_raw < -$signed(half_u)) begin
        diff_r <= d_raw + $signed(wrap_u);
      end else begin
        diff_r <= d_raw;
      end
    end
  end

  // Divisor magnitude with minimum guard
  logic              neg_r;
  logic [DIFF_W-1:0] abs_d;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  min_mag;
  logic [MAG_W-1:0]  divisor;
  logic [NUM_W-1:0]  numerator;
  logic [NUM_W-1:0]  quotient;

  assign abs_d     = diff_r[DIFF_W-1] ? DIFF_W'(-diff_r) : DIFF_W'(diff_r);
  assign mag       = abs_d[MAG_W-1:0];
  assign min_mag   = (min_interval_counts == '0) ? MAG_W'(1) : MAG_W'(min_interval_counts);
  assign numerator = NUM_W'(counter_clock_hz) << FREQ_FRAC_BITS;
  // diff_r is settled in the divisor step; the divider captures this directly
  assign divisor   = (mag < min_mag) ? min_mag : mag;

  always_ff @(posedge clk) begin
    if (cmd.step_mag) begin
      neg_r <= diff_r[DIFF_W-1];
    end
  end

  hcf_divider #(
    .NUM_W (NUM_W),
    .DEN_W (MAG_W)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (cmd.div_start),
    .numerator   (numerator),
    .denominator (divisor),
    .busy        (status.div_busy),
    .quotient    (quotient)
  );

  // Sign and saturation
  logic [SAT_W-1:0]  q_ext;
  logic [SAT_W-1:0]  q_sat;
  logic [OUT_W-1:0]  freq_r;

  assign q_ext = SAT_W'(quotient);

  always_comb begin
    if (neg_r) begin
      q_sat = (q_ext > NEG_LIMIT) ? NEG_LIMIT : q_ext;
    end else begin
      q_sat = (q_ext > POS_LIMIT) ? POS_LIMIT : q_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_sat) begin
      freq_r <= neg_r ? OUT_W'(-q_sat) : OUT_W'(q_sat);
    end
  end

  // Output register doubles as the held frequency
  always_ff @(posedge clk) begin
    if (rst) begin
      elec_freq <= '0;
      stopped   <= 1'b0;
    end else if (cmd.load_out) begin
      if (upd) begin
        elec_freq <= $signed(freq_r);
      end else if (stop_hit) begin
        elec_freq <= '0;
      end
      stopped <= !upd && stop_hit;
    end
  end

  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    stopped |-> (elec_freq == '0))
    else $error("stopped flagged with nonzero frequency");

endmodule

>>> hdl/hcf_ctrl.sv
// ----------------------------------------------------------------------------
// hcf_ctrl: request sequencer
// Steps a request through difference, divisor, division, saturation, output.
// ----------------------------------------------------------------------------
module hcf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  hcf_pkg::hcf_status_t status,
  output hcf_pkg::hcf_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIFF = 6'b000010,
    ST_MAG  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_SAT  = 6'b010000,
    ST_OUT  = 6'b100000
  } hcf_state_t;

  hcf_state_t state;
  hcf_state_t state_next;
  logic       out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.eq ? ST_OUT : ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.step_diff = 1'b1;
        state_next    = ST_MAG;
      end
      ST_MAG: begin
        cmd.step_mag = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        if (!status.div_busy) begin
          state_next = ST_SAT;
        end
      end
      ST_SAT: begin
        cmd.step_sat = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // divider loads on the edge that leaves the divisor step
    cmd.div_start = cmd.step_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.load_out || (out_valid && out_stall);
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> in_stall)
    else $error("new request taken before the current one finished");

  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

endmodule

>>> hdl/hall_capture_frequency.sv
// ----------------------------------------------------------------------------
// hall_capture_frequency: electrical frequency from hall-edge timer captures
// Top level joining the request sequencer and the arithmetic datapath.
// ----------------------------------------------------------------------------
// Each input request carries the latest capture of a free-running timer taken
// at a hall edge. When the capture changed, the block takes the signed
// difference to the previous capture, adds one wrap period (counter_period
// plus one) when the difference lies below minus half that period, raises
// its magnitude to at least min_interval_counts (at least 1) keeping its
// sign, and divides counter_clock_hz * 2^FREQ_FRAC_BITS by it. The quotient
// is truncated, signed and saturated to 41 bits. When the capture is
// unchanged, an idle count runs up to timeout_ticks; a request that finds it
// already there forces the frequency to zero and raises stopped. Otherwise
// the previous frequency is repeated. Every request yields exactly one
// result. A changed capture goes from accept through difference, divisor,
// division, saturation and output load, the serial divider retiring one
// quotient bit per cycle; an unchanged capture goes straight to the output
// load. One request is in work at a time; the output register lets the
// next request be taken while a result still waits on a stalled output.
// Only the low COUNT_WIDTH bits of capture_count are used. Configuration
// writes take effect at once and are meant for idle periods only.
// ----------------------------------------------------------------------------
module hall_capture_frequency #(
  parameter int COUNT_WIDTH    = hcf_pkg::COUNT_WIDTH_DEF,    // 16 to 32
  parameter int FREQ_FRAC_BITS = hcf_pkg::FREQ_FRAC_BITS_DEF  // 0 to 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [hcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hcf_pkg::CFG_W-1:0]         cfg_data,
  // input requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hcf_pkg::CAP_IN_W-1:0]      capture_count,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hcf_pkg::OUT_W-1:0]  elec_freq,
  output logic                              stopped
);

  hcf_pkg::hcf_cmd_t    cmd;
  hcf_pkg::hcf_status_t status;

  // sequencer: one request at a time, output handshake
  hcf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: config, state, difference, divider, output register
  hcf_datapath #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .capture_count (capture_count),
    .cmd           (cmd),
    .status        (status),
    .elec_freq     (elec_freq),
    .stopped       (stopped)
  );

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for hall_capture_frequency
// Drives capture requests through valid/stall, predicts every frequency
// result from a shadow model of the estimator and checks results in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAC      = hcf_pkg::FREQ_FRAC_BITS_DEF;
  localparam int OUT_W     = hcf_pkg::OUT_W;
  localparam int CFG_W     = hcf_pkg::CFG_W;
  localparam int CFG_IDX_W = hcf_pkg::CFG_IDX_W;
  localparam int CAP_IN_W  = hcf_pkg::CAP_IN_W;
  localparam int TMO_W     = hcf_pkg::TMO_W;
  localparam logic [63:0] POS_LIM = (64'd1 << (OUT_W - 1)) - 64'd1;
  localparam logic [63:0] NEG_LIM = 64'd1 << (OUT_W - 1);
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 137;

  // one expected result per request
  typedef struct packed {
    logic [OUT_W-1:0] freq;
    logic             stopped;
  } freq_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = hcf_pkg::REG_COUNTER_PERIOD;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CAP_IN_W-1:0]  capture_count = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [OUT_W-1:0] elec_freq;
  logic                 stopped;

  hall_capture_frequency dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .capture_count (capture_count),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .elec_freq     (elec_freq),
    .stopped       (stopped)
  );

  always #5 clk = ~clk;

  // shadow registers, follow every write
  logic [CFG_W-1:0] sh_period  = hcf_pkg::RST_COUNTER_PERIOD;
  logic [CFG_W-1:0] sh_clock   = hcf_pkg::RST_COUNTER_CLOCK;
  logic [CFG_W-1:0] sh_min_gap = hcf_pkg::RST_MIN_INTERVAL;
  logic [TMO_W-1:0] sh_timeout = hcf_pkg::RST_TIMEOUT;

  // shadow estimator state
  logic [CAP_IN_W-1:0] prev_capture = '0;
  logic [TMO_W-1:0]    idle_count = '0;
  logic [OUT_W-1:0]    held_freq = '0;

  freq_result_t freq_due[$];

  int idle_pct = 0;     // sender: percent of cycles with valid low
  int stall_pct = 0;    // receiver: percent of cycles with stall high
  int repeat_left = 0;  // pending run of unchanged captures
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int stops_seen = 0;
  int reg_writes = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Wrap-corrected interval, guarded magnitude, truncating divide, signed
  // saturation to the output width.
  function automatic logic [OUT_W-1:0] interval_to_freq(
      input logic [CAP_IN_W-1:0] now_cap, input logic [CAP_IN_W-1:0] old_cap);
    logic [63:0]        span, half_span, mag, floor_mag, num, quo, neg_q;
    logic signed [63:0] delta;
    logic               neg;
    span      = {32'd0, sh_period} + 64'd1;
    half_span = span >> 1;
    delta     = $signed({32'd0, now_cap}) - $signed({32'd0, old_cap});
    if (delta < -$signed(half_span)) delta = delta + $signed(span);
    neg       = (delta < 0);
    mag       = neg ? 64'(-delta) : 64'(delta);
    // a zero interval counts as positive; guard is never below one count
    floor_mag = (sh_min_gap == '0) ? 64'd1 : {32'd0, sh_min_gap};
    if (mag < floor_mag) mag = floor_mag;
    num = {32'd0, sh_clock} << FRAC;
    quo = num / mag;
    if (neg) begin
      if (quo > NEG_LIM) quo = NEG_LIM;
      neg_q = 64'd0 - quo;
      return neg_q[OUT_W-1:0];
    end
    if (quo > POS_LIM) quo = POS_LIM;
    return quo[OUT_W-1:0];
  endfunction

  // Advance the shadow estimator by one accepted request.
  task automatic predict_capture(input logic [CAP_IN_W-1:0] cap);
    freq_result_t res;
    res.stopped = 1'b0;
    if (cap != prev_capture) begin
      held_freq  = interval_to_freq(cap, prev_capture);
      idle_count = '0;
    end else if (idle_count < sh_timeout) begin
      idle_count = idle_count + 1'b1;
    end else begin
      // idle count already at the limit: force zero
      held_freq   = '0;
      res.stopped = 1'b1;
    end
    prev_capture = cap;
    res.freq = held_freq;
    freq_due.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= 30)
      $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want,
               results_seen);
  endtask

  // Outputs sampled at the rising edge; a result moves when valid and not
  // stalled. Compared against the oldest prediction.
  always @(posedge clk) begin
    freq_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (stopped) stops_seen++;
      if (freq_due.size() == 0) begin
        report_mismatch("result with nothing pending", {23'd0, elec_freq}, 64'd0);
      end else begin
        want = freq_due.pop_front();
        if (elec_freq !== want.freq)
          report_mismatch("elec_freq", {23'd0, elec_freq}, {23'd0, want.freq});
        if (stopped !== want.stopped)
          report_mismatch("stopped", {63'd0, stopped}, {63'd0, want.stopped});
      end
    end
  end

  // Receiver back-pressure, changes at the falling edge only.
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic set_pressure(input int send_pct, input int recv_pct);
    idle_pct  = send_pct;
    stall_pct = recv_pct;
  endtask

  // One capture request: random sender gaps, hold until accepted.
  task automatic send_capture(input logic [CAP_IN_W-1:0] cap);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    capture_count = cap;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_capture(cap);
    items_sent++;
  endtask

  // Drop valid and let every pending result drain; block is idle after.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (freq_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write, only called with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      hcf_pkg::REG_COUNTER_PERIOD: sh_period  = val;
      hcf_pkg::REG_COUNTER_CLOCK:  sh_clock   = val;
      hcf_pkg::REG_MIN_INTERVAL:   sh_min_gap = val;
      hcf_pkg::REG_TIMEOUT:        sh_timeout = val[TMO_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly forward hall intervals modulo the wrap period; runs of unchanged
  // captures to reach the timeout; some reverse steps and raw noise.
  function automatic logic [CAP_IN_W-1:0] next_capture();
    logic [63:0] span, step;
    int          pick;
    if (repeat_left > 0) begin
      repeat_left--;
      return prev_capture;
    end
    pick = $urandom_range(99);
    if (pick < 14) begin
      repeat_left = (sh_timeout <= 16) ? $urandom_range(0, sh_timeout + 3)
                                       : $urandom_range(0, 6);
      return prev_capture;
    end else if (pick < 70) begin
      span = {32'd0, sh_period} + 64'd1;
      step = {32'd0, $urandom} >> $urandom_range(0, 31);
      if (step == 64'd0) step = 64'd1;
      step = ({32'd0, prev_capture} + step) % span;
      return step[CAP_IN_W-1:0];
    end else if (pick < 84) begin
      step = ({32'd0, $urandom} >> $urandom_range(8, 31)) + 64'd1;
      return prev_capture - step[CAP_IN_W-1:0];
    end
    return $urandom;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset register values: first update measured against zero, hold on an
  // unchanged capture, reverse rotation, top of range, wrap back to zero.
  task automatic test_reset_values();
    set_pressure(0, 0);
    send_capture(32'd64000);
    send_capture(32'd64000);
    send_capture(32'd128000);
    send_capture(32'd120000);
    send_capture(32'hFFFF_FFFF);
    send_capture(32'd0);
    settle();
  endtask

  // Register extremes: fastest clock with one-count guard, widest guard,
  // slowest clock.
  task automatic test_register_extremes();
    set_pressure(22, 22);
    write_reg(hcf_pkg::REG_COUNTER_CLOCK, 32'hFFFF_FFFF);
    write_reg(hcf_pkg::REG_MIN_INTERVAL, 32'd1);
    send_capture(32'd1);
    send_capture(32'd0);
    settle();
    write_reg(hcf_pkg::REG_MIN_INTERVAL, 32'hFFFF_FFFF);
    send_capture(32'd5);
    settle();
    write_reg(hcf_pkg::REG_COUNTER_CLOCK, 32'd1);
    write_reg(hcf_pkg::REG_MIN_INTERVAL, 32'd1);
    send_capture(32'd6);
    settle();
  endtask

  // Zero interval after wrap correction with a zero guard, captures past the
  // reload value, zero counter clock, zero counter period.
  task automatic test_special_cases();
    set_pressure(22, 22);
    write_reg(hcf_pkg::REG_COUNTER_PERIOD, 32'd99);
    write_reg(hcf_pkg::REG_COUNTER_CLOCK, hcf_pkg::RST_COUNTER_CLOCK);
    write_reg(hcf_pkg::REG_MIN_INTERVAL, 32'd0);
    send_capture(32'd156);
    send_capture(32'd56);   // -100 plus one wrap: zero, taken as positive
    send_capture(32'd250);  // beyond the reload value
    send_capture(32'd49);
    settle();
    write_reg(hcf_pkg::REG_COUNTER_CLOCK, 32'd0);
    send_capture(32'd60);
    settle();
    write_reg(hcf_pkg::REG_COUNTER_PERIOD, 32'd0);
    write_reg(hcf_pkg::REG_COUNTER_CLOCK, hcf_pkg::RST_COUNTER_CLOCK);
    write_reg(hcf_pkg::REG_MIN_INTERVAL, 32'd1);
    send_capture(32'd58);
    send_capture(32'd57);
    settle();
  endtask

  // Idle counting: zero timeout forces at once, short timeout counts up,
  // widest timeout merely holds.
  task automatic test_idle_timeout();
    set_pressure(0, 57);
    write_reg(hcf_pkg::REG_COUNTER_PERIOD, hcf_pkg::RST_COUNTER_PERIOD);
    write_reg(hcf_pkg::REG_TIMEOUT, 16'd0);
    send_capture(32'd57);
    send_capture(32'd57);
    settle();
    write_reg(hcf_pkg::REG_TIMEOUT, 16'd2);
    repeat (3) send_capture(32'd57);
    send_capture(32'd1000);
    repeat (4) send_capture(32'd1000);
    settle();
    write_reg(hcf_pkg::REG_TIMEOUT, 16'hFFFF);
    send_capture(32'd1000);
    send_capture(32'd1200);
    settle();
  endtask

  // Random traffic over several register settings and all pressure modes.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] val;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case ($urandom_range(3))
        0: val = 32'hFFFF_FFFF;
        1: val = 32'd65535;
        2: val = $urandom_range(1, 5000);
        default: val = $urandom;
      endcase
      write_reg(hcf_pkg::REG_COUNTER_PERIOD, val);
      case ($urandom_range(3))
        0: val = hcf_pkg::RST_COUNTER_CLOCK;
        1: val = 32'hFFFF_FFFF;
        2: val = $urandom_range(1, 100000);
        default: val = $urandom;
      endcase
      write_reg(hcf_pkg::REG_COUNTER_CLOCK, val);
      case ($urandom_range(4))
        0: val = hcf_pkg::RST_MIN_INTERVAL;
        1: val = 32'd1;
        2: val = $urandom;
        default: val = $urandom_range(0, 8000);
      endcase
      write_reg(hcf_pkg::REG_MIN_INTERVAL, val);
      case ($urandom_range(5))
        0: val = 32'd65535;
        1: val = $urandom_range(0, 65535);
        default: val = $urandom_range(0, 12);
      endcase
      write_reg(hcf_pkg::REG_TIMEOUT, val);
      case (phase % 4)
        0: set_pressure(0, 0);
        1: set_pressure(57, 0);
        2: set_pressure(0, 57);
        default: set_pressure(22, 22);
      endcase
      repeat_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_capture(next_capture());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    test_reset_values();
    test_register_extremes();
    test_special_cases();
    test_idle_timeout();
    test_random_traffic();
    settle();
    // bounded drain, then a quiet period before the summary
    waited = 0;
    while (freq_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (freq_due.size() != 0)
      report_mismatch("results never delivered", 64'(freq_due.size()), 64'd0);
    repeat (100) @(posedge clk);
    $display("Sent %0d capture requests, checked %0d results (%0d timeout stops),",
             items_sent, results_seen, stops_seen);
    $display("with %0d register writes across %0d random phases.", reg_writes, PHASES);
    if (errors == 0) begin
      $display("[hall_capture_frequency] OK");
    end else begin
      $display("[hall_capture_frequency] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Watchdog expired with %0d results pending", freq_due.size());
    $display("[hall_capture_frequency] ERROR");
    $finish;
  end

endmodule
